// File: rtl/mbrc_pkg.sv
// Shared types, constants and the CRC-16 byte step for the Modbus RTU reply checker.
// Used by modbus_rtu_response_checker and mbrc_checker; no dependencies.
`default_nettype none
package mbrc_pkg;

  localparam int BURST_DEPTH = 64;
  localparam int AW          = $clog2(BURST_DEPTH);
  localparam int LEN_W       = AW + 1;
  localparam int SUM_W       = ((LEN_W > 8) ? LEN_W : 8) + 2;
  localparam int RESULT_CAP  = 64;
  localparam int CNT_W       = $clog2(RESULT_CAP + 1);
  localparam int MIN_BURST   = 5;
  localparam int ECHO_LEN    = 8;
  localparam int ECHO_BODY   = 6;
  localparam int READ_HDR    = 3;
  localparam int READ_OVH    = 5;

  localparam logic [7:0]  FC_READ      = 8'h03;
  localparam logic [7:0]  FC_WR_SINGLE = 8'h06;
  localparam logic [7:0]  FC_WR_MULTI  = 8'h10;
  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'hA001;
  localparam logic [7:0]  SLAVE_RESET  = 8'h01;

  localparam logic [1:0] KIND_READ      = 2'd0;
  localparam logic [1:0] KIND_WR_SINGLE = 2'd1;
  localparam logic [1:0] KIND_WR_MULTI  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A0,
    S_A1,
    S_FN,
    S_CNT,
    S_CRC,
    S_LO,
    S_HI,
    S_MARK,
    S_PAY,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] offset;
    logic [7:0] pbyte;
    logic [5:0] pidx;
    logic       pvalid;
    logic       flast;
  } res_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/mbrc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the burst byte store.
`default_nettype none
module mbrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/modbus_rtu_response_checker.sv
// Top level of the Modbus RTU reply checker: byte store, scan sequencer, CRC unit, output stage.
// Depends on mbrc_pkg and mbrc_ram.
`default_nettype none
// Bytes of a burst are taken one per cycle while the block is idle; bytes past the
// 64-entry store are dropped. The item that ends a burst of at least five stored bytes
// starts a scan during which in_ready stays low; a shorter burst is discarded. The scan
// is paced by the single read port of the byte store and the byte-wide CRC-16 unit: at
// each start position it reads the address byte and, on a match, the function code,
// the byte count of a read reply, each body byte into the CRC and the two CRC bytes; a
// valid reply then gives its marker or its payload bytes, and a finish step ends the
// scan. Results leave through an output register and a one-item holding stage, which
// lets run_last be set on the last result of the burst; a stall on the result channel
// stalls the scan. There is no clearing pass after reset.
module modbus_rtu_response_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_slave_address,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       in_burst_end,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_reply_kind,
  output logic [5:0]      out_frame_offset,
  output logic [7:0]      out_payload_byte,
  output logic [5:0]      out_payload_index,
  output logic            out_payload_valid,
  output logic            out_frame_last,
  output logic            out_run_last
);

  mbrc_pkg::state_t state_r, state_nxt;

  logic [7:0]                 slave_r;
  logic [mbrc_pkg::LEN_W-1:0] len_r, len_nxt;
  logic [mbrc_pkg::LEN_W-1:0] pos_r, pos_nxt;
  logic [mbrc_pkg::LEN_W-1:0] k_r, k_nxt;
  logic [mbrc_pkg::LEN_W-1:0] body_r, body_nxt;
  logic [7:0]                 n_r, n_nxt;
  logic [15:0]                crc_r, crc_nxt;
  logic [1:0]                 kind_r, kind_nxt;
  logic [mbrc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  mbrc_pkg::res_t             pend_r, pend_nxt;
  logic                       pend_v_r, pend_v_nxt;
  mbrc_pkg::res_t             out_r, out_nxt;
  logic                       out_v_r, out_v_nxt;
  logic                       out_run_r, out_run_nxt;

  logic                       ram_we;
  logic [mbrc_pkg::AW-1:0]    ram_raddr;
  logic [7:0]                 ram_rdata;

  mbrc_ram #(
    .WIDTH(8),
    .DEPTH(mbrc_pkg::BURST_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(len_r[mbrc_pkg::AW-1:0]),
    .wdata(in_rx_byte),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign cfg_ready         = 1'b1;
  assign in_ready          = (state_r == mbrc_pkg::S_IDLE);
  assign out_valid         = out_v_r;
  assign out_reply_kind    = out_r.kind;
  assign out_frame_offset  = out_r.offset;
  assign out_payload_byte  = out_r.pbyte;
  assign out_payload_index = out_r.pidx;
  assign out_payload_valid = out_r.pvalid;
  assign out_frame_last    = out_r.flast;
  assign out_run_last      = out_run_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= mbrc_pkg::S_IDLE;
      slave_r  <= mbrc_pkg::SLAVE_RESET;
      len_r    <= '0;
      pos_r    <= '0;
      k_r      <= '0;
      cnt_r    <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      len_r    <= len_nxt;
      pos_r    <= pos_nxt;
      k_r      <= k_nxt;
      cnt_r    <= cnt_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
      if (cfg_valid && cfg_ready) begin
        slave_r <= cfg_slave_address;
      end
    end
  end

  always_ff @(posedge clk) begin
    body_r    <= body_nxt;
    n_r       <= n_nxt;
    crc_r     <= crc_nxt;
    kind_r    <= kind_nxt;
    pend_r    <= pend_nxt;
    out_r     <= out_nxt;
    out_run_r <= out_run_nxt;
  end

  always_comb begin
    logic                       slot_free;
    logic                       cap_full;
    logic                       push_req;
    logic                       push_ok;
    mbrc_pkg::res_t             push_res;
    logic                       adv_en;
    logic [mbrc_pkg::LEN_W-1:0] adv_pos;
    logic [mbrc_pkg::LEN_W-1:0] new_len;
    logic [mbrc_pkg::SUM_W-1:0] fit_end;
    logic                       pay_last;

    state_nxt   = state_r;
    len_nxt     = len_r;
    pos_nxt     = pos_r;
    k_nxt       = k_r;
    body_nxt    = body_r;
    n_nxt       = n_r;
    crc_nxt     = crc_r;
    kind_nxt    = kind_r;
    cnt_nxt     = cnt_r;
    pend_nxt    = pend_r;
    pend_v_nxt  = pend_v_r;
    out_nxt     = out_r;
    out_run_nxt = out_run_r;
    out_v_nxt   = out_v_r && !out_ready;
    ram_we      = 1'b0;
    ram_raddr   = pos_r[mbrc_pkg::AW-1:0];

    slot_free = !out_v_r || out_ready;
    cap_full  = (cnt_r >= mbrc_pkg::CNT_W'(mbrc_pkg::RESULT_CAP));
    push_ok   = cap_full || !pend_v_r || slot_free;
    push_req  = 1'b0;
    push_res  = '0;
    adv_en    = 1'b0;
    adv_pos   = pos_r;
    new_len   = len_r;
    fit_end   = '0;
    pay_last  = (mbrc_pkg::SUM_W'(k_r) + mbrc_pkg::SUM_W'(1)) == mbrc_pkg::SUM_W'(n_r);

    unique case (state_r)
      mbrc_pkg::S_IDLE: begin
        if (in_valid) begin
          if (len_r < mbrc_pkg::LEN_W'(mbrc_pkg::BURST_DEPTH)) begin
            ram_we  = 1'b1;
            new_len = len_r + mbrc_pkg::LEN_W'(1);
          end
          len_nxt = new_len;
          if (in_burst_end) begin
            if (new_len >= mbrc_pkg::LEN_W'(mbrc_pkg::MIN_BURST)) begin
              pos_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = mbrc_pkg::S_A0;
            end else begin
              len_nxt = '0;
            end
          end
        end
      end
      mbrc_pkg::S_A0: begin
        state_nxt = mbrc_pkg::S_A1;
      end
      mbrc_pkg::S_A1: begin
        if (ram_rdata == slave_r) begin
          ram_raddr = mbrc_pkg::AW'(pos_r + mbrc_pkg::LEN_W'(1));
          state_nxt = mbrc_pkg::S_FN;
        end else begin
          adv_en  = 1'b1;
          adv_pos = pos_r + mbrc_pkg::LEN_W'(1);
        end
      end
      mbrc_pkg::S_FN: begin
        case (ram_rdata) inside
          mbrc_pkg::FC_READ: begin
            ram_raddr = mbrc_pkg::AW'(pos_r + mbrc_pkg::LEN_W'(2));
            state_nxt = mbrc_pkg::S_CNT;
          end
          mbrc_pkg::FC_WR_SINGLE, mbrc_pkg::FC_WR_MULTI: begin
            kind_nxt = (ram_rdata == mbrc_pkg::FC_WR_SINGLE) ?
                       mbrc_pkg::KIND_WR_SINGLE : mbrc_pkg::KIND_WR_MULTI;
            n_nxt    = '0;
            fit_end  = mbrc_pkg::SUM_W'(pos_r) + mbrc_pkg::SUM_W'(mbrc_pkg::ECHO_LEN);
            if (fit_end > mbrc_pkg::SUM_W'(len_r)) begin
              state_nxt = mbrc_pkg::S_FIN;
            end else begin
              body_nxt  = mbrc_pkg::LEN_W'(mbrc_pkg::ECHO_BODY);
              k_nxt     = '0;
              crc_nxt   = mbrc_pkg::CRC_INIT;
              state_nxt = mbrc_pkg::S_CRC;
            end
          end
          default: begin
            adv_en  = 1'b1;
            adv_pos = pos_r + mbrc_pkg::LEN_W'(1);
          end
        endcase
      end
      mbrc_pkg::S_CNT: begin
        n_nxt    = ram_rdata;
        kind_nxt = mbrc_pkg::KIND_READ;
        fit_end  = mbrc_pkg::SUM_W'(pos_r) + mbrc_pkg::SUM_W'(ram_rdata)
                 + mbrc_pkg::SUM_W'(mbrc_pkg::READ_OVH);
        if (fit_end > mbrc_pkg::SUM_W'(len_r)) begin
          state_nxt = mbrc_pkg::S_FIN;
        end else begin
          body_nxt  = mbrc_pkg::LEN_W'(mbrc_pkg::SUM_W'(ram_rdata)
                    + mbrc_pkg::SUM_W'(mbrc_pkg::READ_HDR));
          k_nxt     = '0;
          crc_nxt   = mbrc_pkg::CRC_INIT;
          state_nxt = mbrc_pkg::S_CRC;
        end
      end
      mbrc_pkg::S_CRC: begin
        crc_nxt = mbrc_pkg::crc_byte(crc_r, ram_rdata);
        if (k_r + mbrc_pkg::LEN_W'(1) == body_r) begin
          ram_raddr = mbrc_pkg::AW'(pos_r + body_r);
          state_nxt = mbrc_pkg::S_LO;
        end else begin
          k_nxt     = k_r + mbrc_pkg::LEN_W'(1);
          ram_raddr = mbrc_pkg::AW'(pos_r + k_r + mbrc_pkg::LEN_W'(1));
        end
      end
      mbrc_pkg::S_LO: begin
        if (ram_rdata == crc_r[7:0]) begin
          ram_raddr = mbrc_pkg::AW'(pos_r + body_r + mbrc_pkg::LEN_W'(1));
          state_nxt = mbrc_pkg::S_HI;
        end else begin
          adv_en  = 1'b1;
          adv_pos = pos_r + mbrc_pkg::LEN_W'(1);
        end
      end
      mbrc_pkg::S_HI: begin
        if (ram_rdata != crc_r[15:8]) begin
          adv_en  = 1'b1;
          adv_pos = pos_r + mbrc_pkg::LEN_W'(1);
        end else if (kind_r != mbrc_pkg::KIND_READ || n_r == 8'd0) begin
          state_nxt = mbrc_pkg::S_MARK;
        end else begin
          k_nxt     = '0;
          ram_raddr = mbrc_pkg::AW'(pos_r + mbrc_pkg::LEN_W'(mbrc_pkg::READ_HDR));
          state_nxt = mbrc_pkg::S_PAY;
        end
      end
      mbrc_pkg::S_MARK: begin
        push_req        = 1'b1;
        push_res.kind   = kind_r;
        push_res.offset = pos_r[5:0];
        push_res.flast  = 1'b1;
        if (push_ok) begin
          adv_en  = 1'b1;
          adv_pos = pos_r + ((kind_r == mbrc_pkg::KIND_READ) ?
                    mbrc_pkg::LEN_W'(mbrc_pkg::READ_OVH) : mbrc_pkg::LEN_W'(mbrc_pkg::ECHO_LEN));
        end
      end
      mbrc_pkg::S_PAY: begin
        push_req        = 1'b1;
        push_res.kind   = mbrc_pkg::KIND_READ;
        push_res.offset = pos_r[5:0];
        push_res.pbyte  = ram_rdata;
        push_res.pidx   = 6'(k_r);
        push_res.pvalid = 1'b1;
        push_res.flast  = pay_last;
        ram_raddr       = mbrc_pkg::AW'(pos_r + k_r + mbrc_pkg::LEN_W'(mbrc_pkg::READ_HDR));
        if (push_ok) begin
          if (pay_last) begin
            adv_en  = 1'b1;
            adv_pos = mbrc_pkg::LEN_W'(mbrc_pkg::SUM_W'(pos_r) + mbrc_pkg::SUM_W'(n_r)
                    + mbrc_pkg::SUM_W'(mbrc_pkg::READ_OVH));
          end else begin
            k_nxt     = k_r + mbrc_pkg::LEN_W'(1);
            ram_raddr = mbrc_pkg::AW'(pos_r + k_r
                      + mbrc_pkg::LEN_W'(mbrc_pkg::READ_HDR + 1));
          end
        end
      end
      mbrc_pkg::S_FIN: begin
        if (!pend_v_r) begin
          len_nxt   = '0;
          state_nxt = mbrc_pkg::S_IDLE;
        end else if (slot_free) begin
          out_nxt     = pend_r;
          out_run_nxt = 1'b1;
          out_v_nxt   = 1'b1;
          pend_v_nxt  = 1'b0;
          len_nxt     = '0;
          state_nxt   = mbrc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mbrc_pkg::S_IDLE;
      end
    endcase

    if (push_req && push_ok && !cap_full) begin
      if (pend_v_r) begin
        out_nxt     = pend_r;
        out_run_nxt = 1'b0;
        out_v_nxt   = 1'b1;
      end
      pend_nxt   = push_res;
      pend_v_nxt = 1'b1;
      cnt_nxt    = cnt_r + mbrc_pkg::CNT_W'(1);
    end

    if (adv_en) begin
      pos_nxt = adv_pos;
      if (mbrc_pkg::SUM_W'(adv_pos) + mbrc_pkg::SUM_W'(mbrc_pkg::MIN_BURST)
          < mbrc_pkg::SUM_W'(len_r)) begin
        state_nxt = mbrc_pkg::S_A0;
      end else begin
        state_nxt = mbrc_pkg::S_FIN;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/mbrc_checker.sv
// Port-level assertions for the Modbus RTU reply checker, bound to the top level.
// Depends on mbrc_pkg and modbus_rtu_response_checker.
`default_nettype none
module mbrc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       cfg_valid,
  input wire logic       cfg_ready,
  input wire logic [7:0] cfg_slave_address,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [7:0] in_rx_byte,
  input wire logic       in_burst_end,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_reply_kind,
  input wire logic [5:0] out_frame_offset,
  input wire logic [7:0] out_payload_byte,
  input wire logic [5:0] out_payload_index,
  input wire logic       out_payload_valid,
  input wire logic       out_frame_last,
  input wire logic       out_run_last
);

  logic cfg_seen;
  logic byte_seen;

  assign cfg_seen  = cfg_valid && cfg_ready && (cfg_slave_address == cfg_slave_address);
  assign byte_seen = (in_rx_byte == in_rx_byte);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload_byte)
      && $stable(out_frame_offset) && $stable(out_run_last))
    else $error("stalled result item changed");

  a_payload_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload_valid |-> out_reply_kind == mbrc_pkg::KIND_READ)
    else $error("payload item on a write echo");

  a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_payload_valid |-> out_payload_byte == 8'd0
      && out_payload_index == 6'd0 && out_frame_last)
    else $error("marker item carries data");

  a_mid_burst_ready: assert property (@(posedge clk) disable iff (!rst_n || cfg_seen)
    in_valid && in_ready && !in_burst_end && byte_seen |=> in_ready)
    else $error("not ready after a byte within a burst");

endmodule

bind modbus_rtu_response_checker mbrc_checker u_mbrc_checker (.*);
`default_nettype wire
